>>> src/srm_pkg.sv
// ----------------------------------------------------------------------------
// srm_pkg: shared types and constants
// Word width, operation and status codes, and the control word that the
// sequencer broadcasts to every sorted cell.
// ----------------------------------------------------------------------------
package srm_pkg;

    localparam int WORD_W    = 32;
    localparam int DEPTH_DEF = 256;

    typedef enum logic [1:0] {
        KIND_PUSH  = 2'd0,
        KIND_POP   = 2'd1,
        KIND_QUERY = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_FULL  = 2'd2
    } t_status;

    // broadcast to all cells in the update cycle
    typedef struct packed {
        logic                     ins;
        logic                     del;
        logic signed [WORD_W-1:0] value;
    } t_cell_ctl;

endpackage

>>> src/srm_cell.sv
// ----------------------------------------------------------------------------
// srm_cell: one slot of the sorted store
// Holds one value; shifts right on insert, left on delete, by comparing its
// own value with the broadcast value and looking at its neighbors.
// ----------------------------------------------------------------------------
module srm_cell (
    input  logic                             i_clk,
    input  srm_pkg::t_cell_ctl               i_ctl,
    input  logic                             i_occ,
    input  logic signed [srm_pkg::WORD_W-1:0] i_left_val,
    input  logic                             i_left_big,
    input  logic signed [srm_pkg::WORD_W-1:0] i_right_val,
    output logic signed [srm_pkg::WORD_W-1:0] o_val,
    output logic                             o_big
);

    logic signed [srm_pkg::WORD_W-1:0] r_val;
    logic signed [srm_pkg::WORD_W-1:0] n_val;
    logic                              w_gt;
    logic                              w_ge;

    assign w_gt  = r_val > i_ctl.value;
    assign w_ge  = r_val >= i_ctl.value;
    // an empty slot counts as larger than anything
    assign o_big = !i_occ || w_gt;
    assign o_val = r_val;

    always_comb begin
        n_val = r_val;
        if (i_ctl.ins && o_big) begin
            // take the left neighbor if it also moves, else land the new word here
            n_val = i_left_big ? i_left_val : i_ctl.value;
        end else if (i_ctl.del && w_ge) begin
            n_val = i_right_val;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

endmodule

>>> src/stack_with_running_median_core.sv
// ----------------------------------------------------------------------------
// stack_with_running_median_core: LIFO stack with lower-median query
// Push, pop and median query on signed 32-bit words. The stack lives in a
// memory; a row of sorted cells keeps the same words in ascending order so
// the median is a direct read.
// ----------------------------------------------------------------------------
//
//  channel | signals                                      | direction
//  --------+----------------------------------------------+----------
//  input   | i_in_valid, o_in_stall, i_kind, i_push_value | in
//  output  | o_out_valid, i_out_stall, o_result_value,    | out
//          | o_status                                     |
//
// Each word passes through an accept cycle and an update cycle: the accept
// cycle reads the stack top from memory and the median slot from the cell
// row into registers, and the update cycle shifts the whole cell row in
// parallel and loads the result. The registered memory read sits ahead of
// the cell update, and the input stalls until that update completes.
// Reset (synchronous, active low) clears the count, the sequencer and the
// output valid; the memory and cells are not cleared and need no sweep.
// A stalled result holds the update cycle of the next result-bearing word;
// a successful push completes while a result is still waiting.
// ----------------------------------------------------------------------------
module stack_with_running_median_core #(
    parameter int DEPTH = srm_pkg::DEPTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [1:0]                        i_kind,
    input  logic signed [srm_pkg::WORD_W-1:0] i_push_value,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic signed [srm_pkg::WORD_W-1:0] o_result_value,
    output logic [1:0]                        o_status
);

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } t_state;

    t_state r_state, n_state;

    // entry count and latched word
    logic [CW-1:0]                     r_count;
    logic [1:0]                        r_kind;
    logic signed [srm_pkg::WORD_W-1:0] r_value;
    logic signed [srm_pkg::WORD_W-1:0] r_top;
    logic signed [srm_pkg::WORD_W-1:0] r_med;

    // output register
    logic                              r_out_valid;
    logic signed [srm_pkg::WORD_W-1:0] r_res_value;
    logic [1:0]                        r_status;

    logic signed [srm_pkg::WORD_W-1:0] r_mem [DEPTH];

    logic                              w_accept;
    logic                              w_full;
    logic                              w_empty;
    logic                              w_has_res;
    logic                              w_go;
    logic                              w_push_ok;
    logic                              w_pop_ok;
    logic [IW-1:0]                     w_top_idx;
    logic [CW-1:0]                     w_count_m1;
    logic [IW-1:0]                     w_med_idx;
    logic signed [srm_pkg::WORD_W-1:0] n_res_value;
    logic [1:0]                        n_status;
    srm_pkg::t_cell_ctl                w_ctl;

    logic signed [srm_pkg::WORD_W-1:0] w_cell_val [DEPTH];
    logic                              w_cell_big [DEPTH];

    assign o_in_stall     = (r_state != ST_IDLE);
    assign w_accept       = i_in_valid && (r_state == ST_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_result_value = r_res_value;
    assign o_status       = r_status;

    assign w_full     = (r_count == CW'(DEPTH));
    assign w_empty    = (r_count == '0);
    assign w_count_m1 = r_count - CW'(1);
    assign w_top_idx  = w_count_m1[IW-1:0];
    assign w_med_idx  = IW'(w_count_m1 >> 1);

    // classify the latched word
    always_comb begin
        w_has_res   = 1'b0;
        w_push_ok   = 1'b0;
        w_pop_ok    = 1'b0;
        n_res_value = '0;
        n_status    = srm_pkg::STAT_OK;
        case (r_kind)
            srm_pkg::KIND_PUSH: begin
                if (w_full) begin
                    w_has_res = 1'b1;
                    n_status  = srm_pkg::STAT_FULL;
                end else begin
                    w_push_ok = 1'b1;
                end
            end
            srm_pkg::KIND_POP: begin
                w_has_res = 1'b1;
                if (w_empty) begin
                    n_status = srm_pkg::STAT_EMPTY;
                end else begin
                    w_pop_ok    = 1'b1;
                    n_res_value = r_top;
                end
            end
            srm_pkg::KIND_QUERY: begin
                w_has_res = 1'b1;
                if (w_empty) begin
                    n_status = srm_pkg::STAT_EMPTY;
                end else begin
                    n_res_value = r_med;
                end
            end
            default: begin
                // unused code: drop the word
            end
        endcase
    end

    // hold the update while a result is still waiting downstream
    assign w_go = (r_state == ST_EXEC) && !(w_has_res && r_out_valid && i_out_stall);

    assign w_ctl.ins   = w_go && w_push_ok;
    assign w_ctl.del   = w_go && w_pop_ok;
    assign w_ctl.value = w_push_ok ? r_value : r_top;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (w_go) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_ctl.ins) begin
                r_count <= r_count + CW'(1);
            end else if (w_ctl.del) begin
                r_count <= w_count_m1;
            end
            if (w_go && w_has_res) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // latch the word and the median slot on accept; load the result on update
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_kind  <= i_kind;
            r_value <= i_push_value;
            r_med   <= w_cell_val[w_med_idx];
        end
        if (w_go && w_has_res) begin
            r_res_value <= n_res_value;
            r_status    <= n_status;
        end
    end

    // stack memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (w_ctl.ins) begin
            r_mem[r_count[IW-1:0]] <= r_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_top <= r_mem[w_top_idx];
        end
    end

    // sorted cell row
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic signed [srm_pkg::WORD_W-1:0] w_left_val;
        logic                              w_left_big;
        logic signed [srm_pkg::WORD_W-1:0] w_right_val;
        logic                              w_occ;

        if (g == 0) begin : g_first
            assign w_left_val = '0;
            assign w_left_big = 1'b0;
        end else begin : g_mid
            assign w_left_val = w_cell_val[g-1];
            assign w_left_big = w_cell_big[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign w_right_val = w_cell_val[g];
        end else begin : g_inner
            assign w_right_val = w_cell_val[g+1];
        end

        assign w_occ = (r_count > CW'(g));

        srm_cell u_cell (
            .i_clk       (i_clk),
            .i_ctl       (w_ctl),
            .i_occ       (w_occ),
            .i_left_val  (w_left_val),
            .i_left_big  (w_left_big),
            .i_right_val (w_right_val),
            .o_val       (w_cell_val[g]),
            .o_big       (w_cell_big[g])
        );
    end

endmodule

>>> sim/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for stack_with_running_median_core
// Drives push, pop and median-query words with random gaps on both sides.
// A queue-based stack and sorted list track the contents and the lower
// median of the block. Each result word is checked against the oldest
// predicted reply.
// ----------------------------------------------------------------------------
module tb;

    localparam int DEPTH          = srm_pkg::DEPTH_DEF;
    localparam int IDLE_PCT       = 37;
    localparam int HOLD_AT_WORD   = 150;   // start the long receiver hold here
    localparam int HOLD_CYCLES    = 400;
    localparam int CALM_FROM      = 400;   // no idling on either side in this
    localparam int CALM_TO        = 600;   // window of accepted words
    localparam int RANDOM_WORDS   = 1000;
    localparam int TAIL_CYCLES    = 20;
    localparam int WATCHDOG_LIMIT = 5000;

    // the one kind code the block must ignore
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0]         kind;
        logic signed [31:0] value;
        bit                 wait_drain;    // hold off until no reply is due
    } t_word;

    typedef struct packed {
        logic signed [31:0] value;
        srm_pkg::t_status   status;
    } t_reply;

    logic               clk        = 1'b0;
    logic               rst_n      = 1'b0;
    logic               in_valid   = 1'b0;
    logic [1:0]         kind       = srm_pkg::KIND_PUSH;
    logic signed [31:0] push_value = '0;
    logic               out_stall  = 1'b0;
    logic               in_stall;
    logic               out_valid;
    logic signed [31:0] result_value;
    logic [1:0]         status;

    // words waiting to be sent, replies waiting to arrive
    t_word              words_to_send[$];
    t_reply             pending_replies[$];

    // shadow of the block: push order and ascending order
    logic signed [31:0] stack_vals[$];
    logic signed [31:0] sorted_vals[$];

    int  words_accepted = 0;
    int  errors         = 0;
    int  quiet_cycles   = 0;
    int  hold_left      = 0;
    bit  hold_done      = 1'b0;
    bit  in_taken       = 1'b0;
    int  gen_depth      = 0;
    int  gen_count      = 0;
    int  n_push, n_pop, n_query, n_full, n_empty, n_ignored, peak_depth;
    t_reply want;
    wire calm = (words_accepted >= CALM_FROM) && (words_accepted < CALM_TO);

    stack_with_running_median_core #(
        .DEPTH(DEPTH)
    ) i_dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_kind         (kind),
        .i_push_value   (push_value),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_result_value (result_value),
        .o_status       (status)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor: apply one accepted word to the shadow stack and queue
    // the reply it causes, if any.
    // ------------------------------------------------------------------
    task automatic stack_median_step(input logic [1:0] k, input logic signed [31:0] v);
        t_reply r;
        int     pos;
        r.value  = '0;
        r.status = srm_pkg::STAT_OK;
        case (k)
            srm_pkg::KIND_PUSH: begin
                n_push++;
                if (stack_vals.size() >= DEPTH) begin
                    // full: drop the value, flag it
                    r.status = srm_pkg::STAT_FULL;
                    pending_replies.push_back(r);
                    n_full++;
                end else begin
                    stack_vals.push_back(v);
                    pos = 0;
                    while (pos < sorted_vals.size() && sorted_vals[pos] <= v) pos++;
                    sorted_vals.insert(pos, v);
                    if (stack_vals.size() > peak_depth) peak_depth = stack_vals.size();
                end
            end
            srm_pkg::KIND_POP: begin
                n_pop++;
                if (stack_vals.size() == 0) begin
                    r.status = srm_pkg::STAT_EMPTY;
                    n_empty++;
                end else begin
                    r.value = stack_vals.pop_back();
                    // drop one copy; equal copies are interchangeable
                    pos = 0;
                    while (sorted_vals[pos] != r.value) pos++;
                    sorted_vals.delete(pos);
                end
                pending_replies.push_back(r);
            end
            srm_pkg::KIND_QUERY: begin
                n_query++;
                if (sorted_vals.size() == 0) begin
                    r.status = srm_pkg::STAT_EMPTY;
                    n_empty++;
                end else begin
                    // lower median: rank ceil(n/2) counted from one
                    r.value = sorted_vals[(sorted_vals.size() - 1) / 2];
                end
                pending_replies.push_back(r);
            end
            default: n_ignored++;
        endcase
    endtask

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(9))
            0:       return 32'sh7fff_ffff;
            1:       return 32'sh8000_0000;
            2, 3:    return int'($urandom_range(8)) - 4;   // force duplicates
            default: return $urandom;
        endcase
    endfunction

    // Queue a word and track the depth the block will have after it.
    task automatic add_word(input logic [1:0] k, input logic signed [31:0] v,
                            input bit drain = 1'b0);
        t_word w;
        w.kind       = k;
        w.value      = v;
        w.wait_drain = drain;
        words_to_send.push_back(w);
        if (k != KIND_UNUSED) gen_count++;
        if (k == srm_pkg::KIND_PUSH && gen_depth < DEPTH) gen_depth++;
        if (k == srm_pkg::KIND_POP && gen_depth > 0) gen_depth--;
    endtask

    // Weighted random word: percentages for push and pop, rest mostly queries.
    task automatic add_random(input int push_pct, input int pop_pct, input bit drain = 1'b0);
        int roll;
        roll = $urandom_range(99);
        if (roll < 3)
            add_word(KIND_UNUSED, $urandom, drain);
        else if (roll < 3 + push_pct)
            add_word(srm_pkg::KIND_PUSH, pick_value(), drain);
        else if (roll < 3 + push_pct + pop_pct)
            add_word(srm_pkg::KIND_POP, $urandom, drain);
        else
            add_word(srm_pkg::KIND_QUERY, $urandom, drain);
    endtask

    // ------------------------------------------------------------------
    // Sequence: build all stimulus, reset, wait for completion, report.
    // ------------------------------------------------------------------
    initial begin
        n_push = 0; n_pop = 0; n_query = 0;
        n_full = 0; n_empty = 0; n_ignored = 0; peak_depth = 0;

        // Directed: empty stack, ignored kind, extreme values, equal values.
        add_word(srm_pkg::KIND_POP,    32'sh0);
        add_word(srm_pkg::KIND_QUERY,  32'shffff_ffff);
        add_word(KIND_UNUSED,          32'sh5a5a_a5a5);
        add_word(srm_pkg::KIND_PUSH,   32'sh7fff_ffff);
        add_word(srm_pkg::KIND_PUSH,   32'sh8000_0000);
        add_word(srm_pkg::KIND_QUERY,  32'sh0);
        add_word(srm_pkg::KIND_PUSH,   32'sh0);
        add_word(srm_pkg::KIND_QUERY,  32'sh0);
        add_word(srm_pkg::KIND_PUSH,   -32'sd1);
        add_word(srm_pkg::KIND_PUSH,   -32'sd1);
        add_word(srm_pkg::KIND_QUERY,  32'sh0);
        add_word(srm_pkg::KIND_POP,    32'sh0);
        add_word(srm_pkg::KIND_QUERY,  32'sh0);
        add_word(srm_pkg::KIND_POP,    32'sh0);
        add_word(srm_pkg::KIND_POP,    32'sh0);
        add_word(srm_pkg::KIND_QUERY,  32'sh0);
        add_word(srm_pkg::KIND_POP,    32'sh0);
        add_word(srm_pkg::KIND_POP,    32'sh0);
        add_word(srm_pkg::KIND_POP,    32'sh0);
        add_word(srm_pkg::KIND_QUERY,  32'sh0);

        // Mixed traffic with a slight upward drift.
        repeat (200) add_random(50, 25);
        // Fill to the top, then overflow a few times and query a full stack.
        while (gen_depth < DEPTH) add_random(85, 5);
        repeat (4) add_word(srm_pkg::KIND_PUSH, pick_value());
        add_word(srm_pkg::KIND_QUERY, $urandom);
        // Drain past empty.
        while (gen_depth > 0) add_random(5, 85);
        repeat (2) add_word(srm_pkg::KIND_POP, $urandom);
        add_word(srm_pkg::KIND_QUERY, $urandom);
        // Pause the sender until all replies are in, then mix again.
        add_random(50, 30, 1'b1);
        while (gen_count < RANDOM_WORDS) add_random(45, 30);

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (words_to_send.size() != 0) @(posedge clk);
        while (pending_replies.size() != 0) @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Ran %0d pushes, %0d pops, %0d median queries, %0d ignored words;",
                 n_push, n_pop, n_query, n_ignored);
        $display("peak depth %0d of %0d, %0d full drops, %0d empty replies, %0d errors.",
                 peak_depth, DEPTH, n_full, n_empty, errors);
        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // ------------------------------------------------------------------
    // Driver: advance to the next word at the falling edge once the last
    // one was taken; hold a stalled word unchanged.
    // ------------------------------------------------------------------
    always @(negedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || in_taken) begin
            if (words_to_send.size() == 0) begin
                in_valid <= 1'b0;
            end else if (words_to_send[0].wait_drain && pending_replies.size() != 0) begin
                in_valid <= 1'b0;              // hold until every reply is back
            end else if (!calm && $urandom_range(99) < IDLE_PCT) begin
                in_valid <= 1'b0;
            end else begin
                in_valid   <= 1'b1;
                kind       <= words_to_send[0].kind;
                push_value <= words_to_send[0].value;
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: random stalls, plus one long hold so the block backs up
    // and stalls its input while the sender keeps offering words.
    // ------------------------------------------------------------------
    always @(negedge clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left = hold_left - 1;
            out_stall <= 1'b1;
        end else if (!hold_done && words_accepted >= HOLD_AT_WORD) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            out_stall <= 1'b1;
        end else begin
            out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
        end
    end

    // ------------------------------------------------------------------
    // Monitor: check the result word first, then predict from the input
    // word taken at this same edge; keep the watchdog last.
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        in_taken = rst_n && in_valid && !in_stall;
        if (rst_n && out_valid && !out_stall) begin
            if (pending_replies.size() == 0) begin
                $error("unexpected result word: result_value %0d status %0d",
                       result_value, status);
                errors++;
            end else begin
                want = pending_replies.pop_front();
                if (result_value !== want.value) begin
                    $error("result_value mismatch: expected %0d actual %0d",
                           want.value, result_value);
                    errors++;
                end
                if (status !== want.status) begin
                    $error("status mismatch: expected %0d actual %0d",
                           want.status, status);
                    errors++;
                end
            end
        end
        if (in_taken) begin
            stack_median_step(kind, push_value);
            void'(words_to_send.pop_front());
            words_accepted++;
        end
        // Count cycles with no traffic on either channel.
        if (in_taken || (rst_n && out_valid && !out_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

endmodule
